// File: src/swsd_pkg.sv
`default_nettype none

package swsd_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int CODE_W = 8;
    localparam int OP_W = 2;
    localparam int STATUS_W = 2;

    localparam logic [CODE_W-1:0] MAX_CODE_RESET = 8'd11;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_DUMP = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BAD   = 2'd3
    } status_t;

    localparam logic [2:0] REG_MAX_CODE_ADDR = 3'd0;

endpackage

`default_nettype wire

// File: src/swsd_ram.sv
`default_nettype none

module swsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/stack_with_sorted_dump.sv
`default_nettype none

// channel  | direction | handshake        | payload
// s_       | in        | tvalid / tready  | tdata: operation, item_code
// m_       | out       | tvalid / tready  | tdata: data_out, tuser: status, tlast
// apb      | in        | psel / penable   | max_code at byte address 0
//
// push, and pop or dump of an empty stack, go through S_PUT; pop first reads the
// entry ram in S_POPRD; S_PUT and S_EMIT wait on the result register
// sorted dump of n codes: one scan pass of the entry ram (S_SCAN, then S_WAIT)
// per distinct value, then S_EMIT for each result of that value; the single ram
// read port and the one compare unit set this order
// reset (aresetn low, synchronous) empties the stack and sets max_code to 11
// the result register holds a transfer while m_tready is low; no new request is
// taken until the current one has placed its last result

module stack_with_sorted_dump #(
    parameter int DEPTH = swsd_pkg::DEPTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [1:0] operation, [9:2] item_code

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] data_out
    output logic [1:0]       m_tuser,   // [1:0] status
    output logic             m_tlast,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = swsd_pkg::CODE_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PUT   = 6'b000010,
        S_POPRD = 6'b000100,
        S_SCAN  = 6'b001000,
        S_WAIT  = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] fill_reg, fill_next;
    logic [DW-1:0] max_code_reg, max_code_next;

    logic                     out_valid_reg, out_valid_next;
    swsd_pkg::status_t        out_status_reg, out_status_next;
    logic [DW-1:0]            out_data_reg, out_data_next;
    logic                     out_last_reg, out_last_next;

    swsd_pkg::status_t        res_status_reg, res_status_next;
    logic [DW-1:0]            res_data_reg, res_data_next;

    logic [AW-1:0] idx_reg, idx_next;
    logic          vld_reg, vld_next;
    logic [DW:0]   min_reg, min_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] lo_reg, lo_next;
    logic          lo_valid_reg, lo_valid_next;
    logic [CW-1:0] emit_cnt_reg, emit_cnt_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [DW-1:0]     rd_data;

    swsd_pkg::op_t     in_op;
    logic [DW-1:0]     in_code;
    logic              s_accept;
    logic              out_free;
    logic              is_full;
    logic              is_empty;
    logic              code_bad;
    logic [CW-1:0]     fill_dec;
    logic [AW-1:0]     last_idx;
    logic              above;
    logic              last_item;
    logic              cfg_write;

    assign in_op    = swsd_pkg::op_t'(s_tdata[1:0]);
    assign in_code  = s_tdata[9:2];
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign is_full  = (fill_reg == CW'(DEPTH));
    assign is_empty = (fill_reg == '0);
    assign code_bad = (in_code == '0) || (in_code > max_code_reg);
    assign fill_dec = fill_reg - 1'b1;
    assign last_idx = fill_dec[AW-1:0];
    assign above    = !lo_valid_reg || (rd_data > lo_reg);
    assign last_item = (CW'(emit_cnt_reg + 1'b1) == fill_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == swsd_pkg::REG_MAX_CODE_ADDR[2])
                       ? {24'd0, max_code_reg} : 32'd0;

    swsd_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_entries (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_code),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        max_code_next   = max_code_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        idx_next        = idx_reg;
        vld_next        = 1'b0;
        min_next        = min_reg;
        cnt_next        = cnt_reg;
        lo_next         = lo_reg;
        lo_valid_next   = lo_valid_reg;
        emit_cnt_next   = emit_cnt_reg;
        wr_en           = 1'b0;
        wr_addr         = fill_reg[AW-1:0];
        rd_en           = 1'b0;
        rd_addr         = idx_reg;

        if (cfg_write && paddr[2] == swsd_pkg::REG_MAX_CODE_ADDR[2]) begin
            max_code_next = pwdata[DW-1:0];
        end

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        // shared compare unit: smallest value above the previous one, with count
        if (vld_reg && above) begin
            if ({1'b0, rd_data} < min_reg) begin
                min_next = {1'b0, rd_data};
                cnt_next = CW'(1);
            end else if ({1'b0, rd_data} == min_reg) begin
                cnt_next = CW'(cnt_reg + 1'b1);
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    res_data_next = '0;
                    case (in_op)
                        swsd_pkg::OP_PUSH: begin
                            state_next = S_PUT;
                            if (is_full) begin
                                res_status_next = swsd_pkg::ST_FULL;
                            end else if (code_bad) begin
                                res_status_next = swsd_pkg::ST_BAD;
                            end else begin
                                res_status_next = swsd_pkg::ST_OK;
                                wr_en     = 1'b1;
                                fill_next = CW'(fill_reg + 1'b1);
                            end
                        end
                        swsd_pkg::OP_POP: begin
                            if (is_empty) begin
                                res_status_next = swsd_pkg::ST_EMPTY;
                                state_next      = S_PUT;
                            end else begin
                                res_status_next = swsd_pkg::ST_OK;
                                rd_en      = 1'b1;
                                rd_addr    = last_idx;
                                fill_next  = fill_dec;
                                state_next = S_POPRD;
                            end
                        end
                        swsd_pkg::OP_DUMP: begin
                            if (is_empty) begin
                                res_status_next = swsd_pkg::ST_EMPTY;
                                state_next      = S_PUT;
                            end else begin
                                lo_valid_next = 1'b0;
                                emit_cnt_next = '0;
                                idx_next      = '0;
                                min_next      = '1;
                                cnt_next      = '0;
                                state_next    = S_SCAN;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_POPRD: begin
                res_data_next = rd_data;
                state_next    = S_PUT;
            end
            S_PUT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_data_next   = res_data_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SCAN: begin
                rd_en    = 1'b1;
                vld_next = 1'b1;
                idx_next = AW'(idx_reg + 1'b1);
                if (idx_reg == last_idx) begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = swsd_pkg::ST_OK;
                    out_data_next   = min_reg[DW-1:0];
                    out_last_next   = last_item;
                    emit_cnt_next   = CW'(emit_cnt_reg + 1'b1);
                    cnt_next        = CW'(cnt_reg - 1'b1);
                    if (cnt_reg == CW'(1)) begin
                        if (last_item) begin
                            state_next = S_IDLE;
                        end else begin
                            lo_next       = min_reg[DW-1:0];
                            lo_valid_next = 1'b1;
                            min_next      = '1;
                            cnt_next      = '0;
                            idx_next      = '0;
                            state_next    = S_SCAN;
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            max_code_reg  <= swsd_pkg::MAX_CODE_RESET;
            out_valid_reg <= 1'b0;
            vld_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            max_code_reg  <= max_code_next;
            out_valid_reg <= out_valid_next;
            vld_reg       <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        idx_reg        <= idx_next;
        min_reg        <= min_next;
        cnt_reg        <= cnt_next;
        lo_reg         <= lo_next;
        lo_valid_reg   <= lo_valid_next;
        emit_cnt_reg   <= emit_cnt_next;
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(DEPTH))
        else $error("fill count above depth");

    a_emit_has_value: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT |-> (cnt_reg != '0) && (emit_cnt_reg < fill_reg))
        else $error("dump emit with no pending value");

    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> fill_reg != '0)
        else $error("scan of empty stack");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_op == swsd_pkg::OP_PUSH && !is_full && !code_bad)
        |=> fill_reg == CW'($past(fill_reg) + 1'b1))
        else $error("accepted push did not grow the stack");

    a_dump_holds_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN || state_reg == S_WAIT || state_reg == S_EMIT)
        |=> $stable(fill_reg))
        else $error("stack changed during dump");

endmodule

`default_nettype wire

// File: sim/stack_dump_checker.sv
`timescale 1ns / 100ps

module stack_dump_checker #(
    parameter int DEPTH = swsd_pkg::DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // [1:0] operation, [9:2] item_code

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,    // [7:0] data_out
    input  logic [1:0]  m_tuser,    // [1:0] status
    input  logic        m_tlast,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,

    output int          fail_count,
    output int          awaited_count
);

    typedef struct packed {
        swsd_pkg::status_t status;
        logic [7:0]        data;
        logic              last;
    } result_t;

    logic [7:0] stack_mem [DEPTH];
    int         stack_fill;
    logic [7:0] code_limit;
    result_t    awaited_results [$];
    result_t    oldest;

    initial begin
        fail_count    = 0;
        awaited_count = 0;
        stack_fill    = 0;
        code_limit    = swsd_pkg::MAX_CODE_RESET;
    end

    task automatic report_error(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic expect_result(input swsd_pkg::status_t status, input logic [7:0] data,
                                 input logic last);
        result_t r;
        r.status = status;
        r.data   = data;
        r.last   = last;
        awaited_results.push_back(r);
    endtask

    // stack update and the results one request should produce
    task automatic apply_request(input swsd_pkg::op_t op, input logic [7:0] code);
        logic [7:0] sorted [DEPTH];
        logic [7:0] held;
        int         j;
        case (op)
            swsd_pkg::OP_PUSH: begin
                if (stack_fill >= DEPTH) begin
                    expect_result(swsd_pkg::ST_FULL, 8'd0, 1'b1);
                end else if (code == 8'd0 || code > code_limit) begin
                    expect_result(swsd_pkg::ST_BAD, 8'd0, 1'b1);
                end else begin
                    stack_mem[stack_fill] = code;
                    stack_fill++;
                    expect_result(swsd_pkg::ST_OK, 8'd0, 1'b1);
                end
            end
            swsd_pkg::OP_POP: begin
                if (stack_fill == 0) begin
                    expect_result(swsd_pkg::ST_EMPTY, 8'd0, 1'b1);
                end else begin
                    stack_fill--;
                    expect_result(swsd_pkg::ST_OK, stack_mem[stack_fill], 1'b1);
                end
            end
            swsd_pkg::OP_DUMP: begin
                if (stack_fill == 0) begin
                    expect_result(swsd_pkg::ST_EMPTY, 8'd0, 1'b1);
                end else begin
                    // insertion sort of a copy, stack left as it is
                    for (int i = 0; i < stack_fill; i++) begin
                        held = stack_mem[i];
                        j = i;
                        while (j > 0 && sorted[j-1] > held) begin
                            sorted[j] = sorted[j-1];
                            j--;
                        end
                        sorted[j] = held;
                    end
                    for (int i = 0; i < stack_fill; i++) begin
                        expect_result(swsd_pkg::ST_OK, sorted[i], i == stack_fill - 1);
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            awaited_results.delete();
            stack_fill = 0;
            code_limit = swsd_pkg::MAX_CODE_RESET;
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    report_error($sformatf("unexpected transfer: status %0d data %0d last %0b",
                                           m_tuser, m_tdata, m_tlast));
                end else begin
                    oldest = awaited_results.pop_front();
                    if (m_tuser !== oldest.status || m_tdata !== oldest.data ||
                        m_tlast !== oldest.last) begin
                        report_error($sformatf(
                            "mismatch: expected status %0d data %0d last %0b, got %0d %0d %0b",
                            oldest.status, oldest.data, oldest.last,
                            m_tuser, m_tdata, m_tlast));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                apply_request(swsd_pkg::op_t'(s_tdata[1:0]), s_tdata[9:2]);
            end
            if (psel && penable && pwrite && pready &&
                paddr == swsd_pkg::REG_MAX_CODE_ADDR) begin
                code_limit = pwdata[7:0];
            end
        end
        awaited_count = awaited_results.size();
    end

endmodule

// File: sim/stack_with_sorted_dump_tb.sv
`timescale 1ns / 100ps

module stack_with_sorted_dump_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 32;
    localparam int TAIL_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 64;
    localparam int PHASES         = 5;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // [1:0] operation, [9:2] item_code
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // [7:0] data_out
    logic [1:0]  m_tuser;    // [1:0] status
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          awaited_count;
    int          quiet_cycles = 0;
    logic        quiet_tail = 1'b0;
    logic        gaps_on = 1'b0;
    logic [7:0]  code_limit_now = swsd_pkg::MAX_CODE_RESET;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    stack_with_sorted_dump i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    stack_dump_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .awaited_count (awaited_count)
    );

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("stack_with_sorted_dump test failed");
        $finish;
    end

    // result side stalls in random bursts, none in the tail
    initial begin : result_stalls
        int burst;
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            burst = $urandom_range(1, 16);
            m_tready <= quiet_tail || ($urandom_range(0, 2) != 0);
            repeat (burst) @(negedge aclk);
        end
    end

    task automatic send_req(input swsd_pkg::op_t op, input logic [7:0] code);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, code, op};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic pause_sender(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (awaited_count != 0) @(negedge aclk);
    endtask

    task automatic write_max_code(input logic [7:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= swsd_pkg::REG_MAX_CODE_ADDR;
        pwdata  <= {24'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        code_limit_now = value;
    endtask

    task automatic random_item(input int push_pct);
        swsd_pkg::op_t op;
        logic [7:0]    code;
        int            pick;
        int            code_sel;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            op = swsd_pkg::OP_NONE;
        end else if (pick < 3 + push_pct) begin
            op = swsd_pkg::OP_PUSH;
        end else if (pick < 88) begin
            op = swsd_pkg::OP_POP;
        end else begin
            op = swsd_pkg::OP_DUMP;
        end
        code_sel = $urandom_range(0, 9);
        if (code_sel < 7) begin
            code = 8'($urandom_range(1, code_limit_now));
        end else if (code_sel == 7) begin
            code = 8'd0;
        end else begin
            code = 8'($urandom_range(0, 255));
        end
        send_req(op, code);
    endtask

    initial begin : stimulus
        logic [7:0] limit_pick;
        int         push_pct;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty stack, code range edges at the reset limit, unused operation
        send_req(swsd_pkg::OP_POP, 8'd0);
        send_req(swsd_pkg::OP_DUMP, 8'd0);
        send_req(swsd_pkg::OP_PUSH, 8'd0);
        send_req(swsd_pkg::OP_PUSH, 8'd12);
        send_req(swsd_pkg::OP_PUSH, 8'd255);
        send_req(swsd_pkg::OP_NONE, 8'hff);
        send_req(swsd_pkg::OP_PUSH, 8'd11);
        send_req(swsd_pkg::OP_DUMP, 8'd0);
        send_req(swsd_pkg::OP_POP, 8'd0);
        // fill with repeated codes, then full with good and bad code, full dump
        for (int i = 0; i < 16; i++) begin
            send_req(swsd_pkg::OP_PUSH, 8'((i * 7) % 11 + 1));
        end
        send_req(swsd_pkg::OP_PUSH, 8'd3);
        send_req(swsd_pkg::OP_PUSH, 8'd0);
        send_req(swsd_pkg::OP_DUMP, 8'd0);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: limit_pick = 8'd255;
                1: limit_pick = 8'd1;
                2: limit_pick = 8'($urandom_range(2, 254));
                3: limit_pick = swsd_pkg::MAX_CODE_RESET;
                default: limit_pick = 8'($urandom_range(1, 255));
            endcase
            write_max_code(limit_pick);
            quiet_tail = (ph == PHASES - 1);
            push_pct = (ph % 2 == 0) ? 60 : 35;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 16 == 0) begin
                    gaps_on = !quiet_tail && ($urandom_range(0, 1) == 1);
                end
                if (ph == 2 && k == PHASE_ITEMS / 2) begin
                    drain_results();
                end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                    pause_sender($urandom_range(1, 16));
                end
                random_item(push_pct);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("stack_with_sorted_dump test passed");
        end else begin
            $display("stack_with_sorted_dump test failed");
        end
        $finish;
    end

endmodule
